@@ hdl/apg_pkg.sv @@
// Package with the shared types, codes and constants of the ARMA process generator.
package apg_pkg;

  // Default number of history entries and coefficient taps per stage.
  localparam int MaxOrderDef = 16;

  // Operation codes carried by an input transaction.
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_WR_AR   = 2'd1;
  localparam logic [1:0] OP_WR_MA   = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_AR_ORDER    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MA_ORDER    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RHO_GAIN    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DRIFT       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TREND_SLOPE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CUMULATIVE  = 3'd5;

  // Configuration write data width.
  localparam int CfgDataW = 32;

  // 1.0 in Q4.20, the reset value of rho.
  localparam logic signed [23:0] RHO_ONE = 24'sd1048576;

  // Input transaction payload.
  typedef struct packed {
    logic        [1:0]  operation;
    logic signed [31:0] innovation;
    logic        [3:0]  coef_index;
    logic signed [23:0] coef_value;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic signed [31:0] series_value;
    logic               saturated;
  } out_item_t;

  // Configuration register set.
  typedef struct packed {
    logic        [4:0]  ar_order;
    logic        [4:0]  ma_order;
    logic signed [23:0] rho_gain;
    logic signed [31:0] drift;
    logic signed [31:0] trend_slope;
    logic               cumulative;
  } cfg_t;

endpackage

@@ hdl/apg_hist_mem.sv @@
// Circular history memory holding past innovations and series values with per-entry valid bits.
module apg_hist_mem #(
  parameter int MAX_ORDER = apg_pkg::MaxOrderDef,
  parameter int IW        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic [IW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i
);

  logic [63:0]          mem [MAX_ORDER];
  logic [MAX_ORDER-1:0] valid_q;
  logic [63:0]          rd_q;
  logic                 rd_valid_q;

  // Valid bits: cleared at reset and on restart, set on each write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // Storage array with a registered read port.
  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // An entry never written since restart reads as zero.
  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

@@ hdl/apg_coef_mem.sv @@
// Coefficient memory for the AR and MA taps with per-entry valid bits cleared at reset.
module apg_coef_mem #(
  parameter int MAX_ORDER = apg_pkg::MaxOrderDef,
  parameter int IW        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IW:0]          rd_addr_i,
  output logic signed [23:0]   rd_data_o,
  input  logic                 wr_en_i,
  input  logic [IW:0]          wr_addr_i,
  input  logic signed [23:0]   wr_data_i
);

  localparam int Depth = 2 ** (IW + 1);

  logic [23:0]      mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [23:0]      rd_q;
  logic             rd_valid_q;

  // Valid bits: all coefficients read as zero until loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // Storage array with a registered read port.
  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_valid_q ? $signed(rd_q) : 24'sd0;

endmodule

@@ hdl/apg_seq.sv @@
// Sequencer and shared multiply-accumulate datapath of the ARMA process generator.
module apg_seq #(
  parameter int MAX_ORDER = apg_pkg::MaxOrderDef,
  parameter int IW        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apg_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  apg_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output apg_pkg::out_item_t  out_item_o,
  output logic [IW-1:0]       hist_rd_addr_o,
  input  logic [63:0]         hist_rd_data_i,
  output logic                hist_wr_en_o,
  output logic [IW-1:0]       hist_wr_addr_o,
  output logic [63:0]         hist_wr_data_o,
  output logic                hist_clear_o,
  output logic [IW:0]         coef_rd_addr_o,
  input  logic signed [23:0]  coef_rd_data_i,
  output logic                coef_wr_en_o,
  output logic [IW:0]         coef_wr_addr_o,
  output logic signed [23:0]  coef_wr_data_o
);

  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam logic [IW-1:0] LastSlot = IW'(MAX_ORDER - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MA,
    S_AR,
    S_DRAIN,
    S_ROUND,
    S_RHO_HI,
    S_RHO_LO,
    S_RHO_ADD,
    S_RHO_FIN,
    S_CLIP,
    S_SUM
  } state_e;

  state_e state_q, state_d;

  // Control registers.
  logic [IW-1:0]      head_q, head_d;
  logic [IW-1:0]      slot_q, slot_d;
  logic [IW-1:0]      tap_q, tap_d;
  logic               v1_q, v1_d;
  logic               v2_q, v2_d;
  logic               sel1_q, sel1_d;
  logic               issue_ar;
  logic signed [47:0] rsum_q, rsum_d;
  logic [31:0]        count_q, count_d;
  logic               out_valid_q, out_valid_d;
  apg_pkg::out_item_t out_item_q, out_item_d;

  // Datapath registers.
  logic signed [63:0] acc_q, acc_d;
  logic signed [67:0] sum_q, sum_d;
  logic signed [75:0] rho_q, rho_d;
  logic signed [65:0] prod_q, prod_d;
  logic signed [31:0] e_q, e_d;
  logic signed [31:0] u_q, u_d;
  logic               sat_q, sat_d;

  logic [OW-1:0]      p_ord, q_ord;
  logic [IW-1:0]      head_m1, slot_m1;
  logic               last_ma, last_ar;
  logic signed [32:0] mul_a, mul_b;
  logic signed [24:0] rho_m1;
  logic               accept;
  logic               out_free;
  logic [7:0]         coef_idx_x;
  logic signed [48:0] rsum_add;
  logic signed [47:0] rsum_new;
  logic               rsum_clip;
  logic signed [31:0] cum_val;
  logic               cum_clip;
  logic               clip_hi, clip_lo;

  // Orders above the table depth use every tap.
  assign p_ord = (8'(cfg_i.ar_order) > 8'(MAX_ORDER)) ? OW'(MAX_ORDER) : OW'(cfg_i.ar_order);
  assign q_ord = (8'(cfg_i.ma_order) > 8'(MAX_ORDER)) ? OW'(MAX_ORDER) : OW'(cfg_i.ma_order);

  // Circular slot arithmetic for the history walk.
  assign head_m1 = (head_q == '0) ? LastSlot : head_q - 1'b1;
  assign slot_m1 = (slot_q == '0) ? LastSlot : slot_q - 1'b1;
  assign last_ma = ((IW + 1)'(tap_q) + 1'b1) == (IW + 1)'(q_ord);
  assign last_ar = ((IW + 1)'(tap_q) + 1'b1) == (IW + 1)'(p_ord);

  assign rho_m1     = $signed({cfg_i.rho_gain[23], cfg_i.rho_gain}) - 25'sd1048576;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign coef_idx_x = {4'b0, in_item_i.coef_index};

  // Memory addressing: reads follow the tap walk, writes come from commands and results.
  assign issue_ar       = (state_q == S_AR);
  assign hist_rd_addr_o = slot_q;
  assign coef_rd_addr_o = {issue_ar ? 1'b0 : 1'b1, tap_q};
  assign hist_wr_en_o   = (state_q == S_CLIP);
  assign hist_wr_addr_o = head_q;
  assign hist_wr_data_o = {e_q, u_d};
  assign hist_clear_o   = accept && (in_item_i.operation == apg_pkg::OP_RESTART);
  assign coef_wr_en_o   = accept && (coef_idx_x < 8'(MAX_ORDER)) &&
                          ((in_item_i.operation == apg_pkg::OP_WR_AR) ||
                           (in_item_i.operation == apg_pkg::OP_WR_MA));
  assign coef_wr_addr_o = {(in_item_i.operation == apg_pkg::OP_WR_AR) ? 1'b0 : 1'b1,
                           IW'(in_item_i.coef_index)};
  assign coef_wr_data_o = in_item_i.coef_value;

  // Shared multiplier operands: tap data while the walk drains, else the scalar terms.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (v1_q) begin
      mul_a = sel1_q ? 33'(signed'(hist_rd_data_i[31:0])) : 33'(signed'(hist_rd_data_i[63:32]));
      mul_b = 33'(coef_rd_data_i);
    end else begin
      case (state_q)
        S_ROUND: begin
          mul_a = 33'(cfg_i.trend_slope);
          mul_b = {1'b0, count_q};
        end
        S_RHO_HI: begin
          mul_a = 33'(signed'(rsum_q[47:24]));
          mul_b = 33'(rho_m1);
        end
        S_RHO_LO: begin
          mul_a = {9'b0, rsum_q[23:0]};
          mul_b = 33'(rho_m1);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign prod_d = mul_a * mul_b;

  // Saturation of the series value to Q16.16.
  assign clip_hi = sum_q > 68'sd2147483647;
  assign clip_lo = sum_q < -68'sd2147483648;

  // Running sum update with 48-bit saturation and optional 32-bit output clip.
  assign rsum_add  = {rsum_q[47], rsum_q} + 49'(u_q);
  assign rsum_clip = rsum_add[48] != rsum_add[47];
  assign rsum_new  = !rsum_clip ? rsum_add[47:0] :
                     (rsum_add[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}});
  assign cum_clip  = !((&rsum_new[47:31]) || !(|rsum_new[47:31]));
  assign cum_val   = !cum_clip ? rsum_new[31:0] :
                     (rsum_new[47] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}});

  // Next-state and datapath logic.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    slot_d      = slot_q;
    tap_d       = tap_q;
    v1_d        = 1'b0;
    v2_d        = v1_q;
    sel1_d      = issue_ar;
    rsum_d      = rsum_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    acc_d       = acc_q;
    sum_d       = sum_q;
    rho_d       = rho_q;
    e_d         = e_q;
    u_d         = u_q;
    sat_d       = sat_q;

    // Tap products enter the accumulator after the registered memory read and the product register.
    if (v2_q) begin
      acc_d = acc_q + prod_q[63:0];
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_item_i.operation)
            apg_pkg::OP_SAMPLE: begin
              e_d     = in_item_i.innovation;
              acc_d   = {{12{in_item_i.innovation[31]}}, in_item_i.innovation, 20'b0}
                        + 64'sd524288;
              count_d = (count_q == '1) ? count_q : count_q + 1'b1;
              tap_d   = '0;
              slot_d  = head_m1;
              if (q_ord != '0) begin
                state_d = S_MA;
              end else if (p_ord != '0) begin
                state_d = S_AR;
              end else begin
                state_d = S_DRAIN;
              end
            end
            apg_pkg::OP_RESTART: begin
              rsum_d  = '0;
              count_d = '0;
              head_d  = '0;
            end
            default: begin
              // Coefficient writes go straight to the memory.
            end
          endcase
        end
      end
      S_MA: begin
        v1_d   = 1'b1;
        tap_d  = tap_q + 1'b1;
        slot_d = slot_m1;
        if (last_ma) begin
          tap_d  = '0;
          slot_d = head_m1;
          state_d = (p_ord != '0) ? S_AR : S_DRAIN;
        end
      end
      S_AR: begin
        v1_d   = 1'b1;
        tap_d  = tap_q + 1'b1;
        slot_d = slot_m1;
        if (last_ar) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        // Accumulator already holds the rounding half, so a floor shift rounds.
        sum_d = {{24{acc_q[63]}}, acc_q[63:20]};
        if (p_ord != '0) begin
          sum_d   = {{24{acc_q[63]}}, acc_q[63:20]} + 68'(cfg_i.drift);
          state_d = S_RHO_HI;
        end else begin
          state_d = S_CLIP;
        end
      end
      S_RHO_HI: begin
        // Trend product arrives here.
        sum_d   = sum_q + 68'(prod_q);
        state_d = S_RHO_LO;
      end
      S_RHO_LO: begin
        // Upper half of the running sum times (rho - 1), plus the rounding half.
        rho_d   = (76'(prod_q) <<< 24) + 76'sd524288;
        state_d = S_RHO_ADD;
      end
      S_RHO_ADD: begin
        rho_d   = rho_q + 76'(prod_q);
        state_d = S_RHO_FIN;
      end
      S_RHO_FIN: begin
        sum_d   = sum_q + 68'(rho_q >>> 20);
        state_d = S_CLIP;
      end
      S_CLIP: begin
        sat_d   = clip_hi || clip_lo;
        u_d     = clip_hi ? 32'sh7fffffff : (clip_lo ? 32'sh80000000 : sum_q[31:0]);
        head_d  = (head_q == LastSlot) ? '0 : head_q + 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        if (out_free) begin
          rsum_d      = rsum_new;
          out_valid_d = 1'b1;
          if (cfg_i.cumulative) begin
            out_item_d.series_value = cum_val;
            out_item_d.saturated    = sat_q || rsum_clip || cum_clip;
          end else begin
            out_item_d.series_value = u_q;
            out_item_d.saturated    = sat_q || rsum_clip;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, control registers and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      slot_q      <= '0;
      tap_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      sel1_q      <= 1'b0;
      rsum_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      slot_q      <= slot_d;
      tap_q       <= tap_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      sel1_q      <= sel1_d;
      rsum_q      <= rsum_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  // Arithmetic payload registers.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    sum_q  <= sum_d;
    rho_q  <= rho_d;
    prod_q <= prod_d;
    e_q    <= e_d;
    u_q    <= u_d;
    sat_q  <= sat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hdl/arma_process_generator_unit.sv @@
// Top level of the ARMA process generator: configuration registers, memories and sequencer.
// A sample walks the q MA taps, then the p AR taps (q and p being the MA and AR orders); the
// shared multiplier walks one tap a cycle, then forms the trend and rho terms, which are used
// only when p is nonzero. Coefficient writes and restarts are handled without leaving idle.
// A result appears in the same cycle as the next item can be taken; both wait while the
// output is stalled. Reset clears control state, configuration and valid bits at once.
module arma_process_generator_unit #(
  parameter int MAX_ORDER = apg_pkg::MaxOrderDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  apg_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output apg_pkg::out_item_t              out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [apg_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [apg_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  apg_pkg::cfg_t      cfg_q, cfg_d;
  logic [IW-1:0]      hist_rd_addr;
  logic [63:0]        hist_rd_data;
  logic               hist_wr_en;
  logic [IW-1:0]      hist_wr_addr;
  logic [63:0]        hist_wr_data;
  logic               hist_clear;
  logic [IW:0]        coef_rd_addr;
  logic signed [23:0] coef_rd_data;
  logic               coef_wr_en;
  logic [IW:0]        coef_wr_addr;
  logic signed [23:0] coef_wr_data;

  assign cfg_ready_o = 1'b1;

  // Register decoder for configuration transactions.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        apg_pkg::CFG_AR_ORDER:    cfg_d.ar_order    = cfg_data_i[4:0];
        apg_pkg::CFG_MA_ORDER:    cfg_d.ma_order    = cfg_data_i[4:0];
        apg_pkg::CFG_RHO_GAIN:    cfg_d.rho_gain    = cfg_data_i[23:0];
        apg_pkg::CFG_DRIFT:       cfg_d.drift       = cfg_data_i;
        apg_pkg::CFG_TREND_SLOPE: cfg_d.trend_slope = cfg_data_i;
        apg_pkg::CFG_CUMULATIVE:  cfg_d.cumulative  = cfg_data_i[0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ar_order: '0, ma_order: '0, rho_gain: apg_pkg::RHO_ONE,
                 drift: '0, trend_slope: '0, cumulative: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  apg_hist_mem #(
    .MAX_ORDER (MAX_ORDER),
    .IW        (IW)
  ) u_hist_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (hist_clear),
    .rd_addr_i (hist_rd_addr),
    .rd_data_o (hist_rd_data),
    .wr_en_i   (hist_wr_en),
    .wr_addr_i (hist_wr_addr),
    .wr_data_i (hist_wr_data)
  );

  apg_coef_mem #(
    .MAX_ORDER (MAX_ORDER),
    .IW        (IW)
  ) u_coef_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (coef_rd_addr),
    .rd_data_o (coef_rd_data),
    .wr_en_i   (coef_wr_en),
    .wr_addr_i (coef_wr_addr),
    .wr_data_i (coef_wr_data)
  );

  apg_seq #(
    .MAX_ORDER (MAX_ORDER),
    .IW        (IW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_item_i      (in_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_o     (out_item_o),
    .hist_rd_addr_o (hist_rd_addr),
    .hist_rd_data_i (hist_rd_data),
    .hist_wr_en_o   (hist_wr_en),
    .hist_wr_addr_o (hist_wr_addr),
    .hist_wr_data_o (hist_wr_data),
    .hist_clear_o   (hist_clear),
    .coef_rd_addr_o (coef_rd_addr),
    .coef_rd_data_i (coef_rd_data),
    .coef_wr_en_o   (coef_wr_en),
    .coef_wr_addr_o (coef_wr_addr),
    .coef_wr_data_o (coef_wr_data)
  );

endmodule
